// ===== src/dofc_pkg.sv =====
// Shared types, widths and register codes for the depth-of-field composite core.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dofc_pkg;

    // Color channel width (Q0.COLOR_BITS); valid range 8..32.
    localparam int COLOR_BITS  = 16;
    localparam int COC_BITS    = 16;
    localparam int RADIUS_BITS = 16;
    localparam int WEIGHT_BITS = 17;
    localparam int FRAC_BITS   = 16;
    localparam int STRENGTH_BITS = 17;

    // One quotient bit per divider stage.
    localparam int DIV_STAGES = RADIUS_BITS;

    // Smoothstep datapath widths.
    localparam int SQ_BITS   = 2 * WEIGHT_BITS;
    localparam int TQ_BITS   = WEIGHT_BITS + 1;
    localparam int PROD_BITS = SQ_BITS + TQ_BITS;

    // Blend accumulator: signed diff times signed weight plus a << 16.
    localparam int BLEND_ACC_BITS = COLOR_BITS + WEIGHT_BITS + 3;

    localparam logic [WEIGHT_BITS-1:0] ONE_Q16   = WEIGHT_BITS'(65536);
    localparam logic [TQ_BITS-1:0]     SMOOTH_K  = TQ_BITS'(196608);
    localparam logic [PROD_BITS:0]     SMOOTH_RND = (PROD_BITS + 1)'(64'h8000_0000);
    localparam logic signed [BLEND_ACC_BITS-1:0] BLEND_RND = BLEND_ACC_BITS'(32768);

    // Configuration port.
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_BLUR_RADIUS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR_DILATION   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_EFFECT_STRENGTH = CFG_INDEX_BITS'(2);

    localparam logic [RADIUS_BITS-1:0]   RST_MAX_BLUR_RADIUS = RADIUS_BITS'(2048);
    localparam logic [RADIUS_BITS-1:0]   RST_NEAR_DILATION   = '0;
    localparam logic [STRENGTH_BITS-1:0] RST_EFFECT_STRENGTH = STRENGTH_BITS'(65536);

    // Word traveling through the divider stages.
    typedef struct packed {
        logic [RADIUS_BITS-1:0] rem;
        logic [RADIUS_BITS-1:0] quo;
        logic                   sat;
        logic                   act;
        logic                   neg;
        logic [COLOR_BITS-1:0]  sharp;
        logic [COLOR_BITS-1:0]  near_color;
        logic [COLOR_BITS-1:0]  far_color;
    } div_word_t;

    // Word traveling through the blend stages.
    typedef struct packed {
        logic [COLOR_BITS-1:0]  sharp;
        logic [COLOR_BITS-1:0]  near_color;
        logic [COLOR_BITS-1:0]  far_color;
        logic [WEIGHT_BITS-1:0] wn;
        logic [WEIGHT_BITS-1:0] wf;
    } pix_t;

endpackage

`default_nettype wire

// ===== src/dofc_front.sv =====
// Input stage: forms the CoC magnitude, decides side and saturation, seeds the divider.
// Depends on dofc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dofc_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 adv,
    input  wire logic                                 in_valid,
    input  wire logic signed [dofc_pkg::COC_BITS-1:0] coc_size,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]      sharp_color,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]      near_blur_color,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]      far_blur_color,
    input  wire logic [dofc_pkg::RADIUS_BITS-1:0]     max_blur_radius,
    input  wire logic [dofc_pkg::RADIUS_BITS-1:0]     near_dilation,
    output logic                                      out_valid,
    output dofc_pkg::div_word_t                       out_word
);

    logic                 valid_reg;
    dofc_pkg::div_word_t  word_reg;
    dofc_pkg::div_word_t  word_next;

    always_comb begin
        logic [dofc_pkg::COC_BITS-1:0]    raw;
        logic                             neg;
        logic [dofc_pkg::RADIUS_BITS:0]   mag;
        logic [dofc_pkg::RADIUS_BITS:0]   x;
        logic                             act;
        logic                             sat;
        raw = coc_size;
        neg = raw[dofc_pkg::COC_BITS-1];
        // Near magnitude is 1..32768, plus dilation stays within 17 bits.
        mag = (dofc_pkg::RADIUS_BITS + 1)'(17'h10000) - {1'b0, raw} + {1'b0, near_dilation};
        x   = neg ? mag : {1'b0, raw};
        act = (max_blur_radius != '0) && (neg || (raw != '0));
        sat = x >= {1'b0, max_blur_radius};
        word_next.rem        = (act && !sat) ? x[dofc_pkg::RADIUS_BITS-1:0] : '0;
        word_next.quo        = '0;
        word_next.sat        = sat;
        word_next.act        = act;
        word_next.neg        = neg;
        word_next.sharp      = sharp_color;
        word_next.near_color = near_blur_color;
        word_next.far_color  = far_blur_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== src/dofc_divider.sv =====
// Restoring divider, one quotient bit per register stage: (x << 16) / max_blur_radius.
// Depends on dofc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dofc_divider (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             adv,
    input  wire logic                             in_valid,
    input  wire dofc_pkg::div_word_t              in_word,
    input  wire logic [dofc_pkg::RADIUS_BITS-1:0] max_blur_radius,
    output logic                                  out_valid,
    output dofc_pkg::div_word_t                   out_word
);

    localparam int N = dofc_pkg::DIV_STAGES;

    logic [N-1:0]         valid_reg;
    dofc_pkg::div_word_t  stage_reg  [N];
    dofc_pkg::div_word_t  stage_next [N];

    // Shift in one dividend zero bit, subtract the divisor when it fits.
    function automatic dofc_pkg::div_word_t div_step(
        input dofc_pkg::div_word_t             w,
        input logic [dofc_pkg::RADIUS_BITS-1:0] d
    );
        dofc_pkg::div_word_t              res;
        logic [dofc_pkg::RADIUS_BITS:0]   r2;
        logic [dofc_pkg::RADIUS_BITS:0]   diff;
        logic                             ge;
        res  = w;
        r2   = {w.rem, 1'b0};
        diff = r2 - {1'b0, d};
        ge   = r2 >= {1'b0, d};
        res.rem = ge ? diff[dofc_pkg::RADIUS_BITS-1:0] : r2[dofc_pkg::RADIUS_BITS-1:0];
        res.quo = {w.quo[dofc_pkg::RADIUS_BITS-2:0], ge};
        return res;
    endfunction

    always_comb begin
        stage_next[0] = div_step(in_word, max_blur_radius);
        for (int i = 1; i < N; i++) begin
            stage_next[i] = div_step(stage_reg[i-1], max_blur_radius);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_word  = stage_reg[N-1];

endmodule

`default_nettype wire

// ===== src/dofc_smooth.sv =====
// Smoothstep 3w^2 - 2w^3 in Q1.16 over three register stages; steers it to near or far.
// Depends on dofc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dofc_smooth (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire dofc_pkg::div_word_t  in_word,
    output logic                      out_valid,
    output dofc_pkg::pix_t            out_pix
);

    typedef struct packed {
        logic                            neg;
        logic [dofc_pkg::COLOR_BITS-1:0] sharp;
        logic [dofc_pkg::COLOR_BITS-1:0] near_color;
        logic [dofc_pkg::COLOR_BITS-1:0] far_color;
    } col_t;

    logic [2:0]                        valid_reg;
    logic [dofc_pkg::SQ_BITS-1:0]      sq_reg,  sq_next;
    logic [dofc_pkg::TQ_BITS-1:0]      tq_reg,  tq_next;
    logic [dofc_pkg::PROD_BITS-1:0]    prod_reg, prod_next;
    col_t                              col1_reg, col1_next;
    col_t                              col2_reg;
    dofc_pkg::pix_t                    pix_reg, pix_next;

    // Stage 1: pick the weight argument, square it, form 3 - 2w.
    always_comb begin
        logic [dofc_pkg::WEIGHT_BITS-1:0] w;
        if (!in_word.act) begin
            w = '0;
        end else if (in_word.sat) begin
            w = dofc_pkg::ONE_Q16;
        end else begin
            w = {1'b0, in_word.quo};
        end
        sq_next = {{dofc_pkg::WEIGHT_BITS{1'b0}}, w} * {{dofc_pkg::WEIGHT_BITS{1'b0}}, w};
        tq_next = dofc_pkg::SMOOTH_K - {w, 1'b0};
        col1_next.neg        = in_word.neg;
        col1_next.sharp      = in_word.sharp;
        col1_next.near_color = in_word.near_color;
        col1_next.far_color  = in_word.far_color;
    end

    // Stage 2: w^2 * (3 - 2w).
    assign prod_next = {{dofc_pkg::TQ_BITS{1'b0}}, sq_reg}
                     * {{dofc_pkg::SQ_BITS{1'b0}}, tq_reg};

    // Stage 3: round, clamp and steer.
    always_comb begin
        logic [dofc_pkg::PROD_BITS:0]      sum;
        logic [dofc_pkg::PROD_BITS-32:0]   hi;
        logic [dofc_pkg::WEIGHT_BITS-1:0]  s;
        sum = {1'b0, prod_reg} + dofc_pkg::SMOOTH_RND;
        hi  = sum[dofc_pkg::PROD_BITS:32];
        s   = (hi > (dofc_pkg::PROD_BITS - 31)'(dofc_pkg::ONE_Q16)) ? dofc_pkg::ONE_Q16
                                                                  : hi[dofc_pkg::WEIGHT_BITS-1:0];
        pix_next.sharp      = col2_reg.sharp;
        pix_next.near_color = col2_reg.near_color;
        pix_next.far_color  = col2_reg.far_color;
        pix_next.wn         = col2_reg.neg ? s : '0;
        pix_next.wf         = col2_reg.neg ? '0 : s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg   <= sq_next;
            tq_reg   <= tq_next;
            col1_reg <= col1_next;
            prod_reg <= prod_next;
            col2_reg <= col1_reg;
            pix_reg  <= pix_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_pix   = pix_reg;

endmodule

`default_nettype wire

// ===== src/dofc_blend.sv =====
// One rounded lerp stage: c = (a*(1-t) + b*t + 0.5) in Q0.COLOR_BITS, registered.
// Depends on dofc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dofc_blend (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             adv,
    input  wire logic                             in_valid,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]  a,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]  b,
    input  wire logic [dofc_pkg::WEIGHT_BITS-1:0] t,
    input  wire dofc_pkg::pix_t                   in_pix,
    output logic                                  out_valid,
    output logic [dofc_pkg::COLOR_BITS-1:0]       out_color,
    output dofc_pkg::pix_t                        out_pix
);

    localparam int ACC = dofc_pkg::BLEND_ACC_BITS;

    logic                              valid_reg;
    logic [dofc_pkg::COLOR_BITS-1:0]   c_reg, c_next;
    dofc_pkg::pix_t                    pix_reg;

    // a*(1-t) + b*t == (a << 16) + (b - a)*t: one signed multiplier.
    always_comb begin
        logic signed [dofc_pkg::COLOR_BITS:0]  diff;
        logic signed [dofc_pkg::WEIGHT_BITS:0] ts;
        logic signed [ACC-1:0]                 acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        ts   = $signed({1'b0, t});
        acc  = ACC'(diff) * ACC'(ts)
             + $signed(ACC'({a, {dofc_pkg::FRAC_BITS{1'b0}}}))
             + dofc_pkg::BLEND_RND;
        c_next = acc[dofc_pkg::FRAC_BITS +: dofc_pkg::COLOR_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg   <= c_next;
            pix_reg <= in_pix;
        end
    end

    assign out_valid = valid_reg;
    assign out_color = c_reg;
    assign out_pix   = pix_reg;

endmodule

`default_nettype wire

// ===== src/depth_of_field_pixel_composite_core.sv =====
// Top level of the depth-of-field composite: config registers, pipeline control, stages.
// Depends on dofc_pkg, dofc_front, dofc_divider, dofc_smooth, dofc_blend.
//
// Usage:
//   Input channel (s_valid/s_ready) takes one word per pixel channel: a signed Q8.8
//   circle-of-confusion size and sharp, near-blurred and far-blurred color samples.
//   Result channel (m_valid/m_ready) gives the composited color plus the near and
//   far smoothstep weights (Q1.16), one result word per input word, in order.
//   Config channel (cfg_valid/cfg_ready, always ready) writes max_blur_radius
//   (index 0), near_dilation (index 1) and effect_strength (index 2); other
//   indexes are dropped. Write config only while the pipeline is empty.
//   Throughput: one word per cycle when not stalled. Stages from acceptance to
//   m_valid: 1 front stage, 16 divider stages at one quotient bit each, 3
//   smoothstep stages, 3 blend stages; the last blend register is the output.
//   Stall: when the receiver holds m_ready low with a word waiting, the whole
//   pipeline freezes and s_ready drops in the same cycle; nothing is lost or
//   repeated, and s_ready returns as soon as the output word is taken.
//   Reset (aresetn low, synchronous): all valid bits clear, config registers
//   return to 2048 / 0 / 65536.
`timescale 1ns / 1ps
`default_nettype none

module depth_of_field_pixel_composite_core (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // input words
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [dofc_pkg::COC_BITS-1:0]    s_coc_size,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]         s_sharp_color,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]         s_near_blur_color,
    input  wire logic [dofc_pkg::COLOR_BITS-1:0]         s_far_blur_color,
    // result words
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [dofc_pkg::COLOR_BITS-1:0]              m_result_color,
    output logic [dofc_pkg::WEIGHT_BITS-1:0]             m_near_weight,
    output logic [dofc_pkg::WEIGHT_BITS-1:0]             m_far_weight,
    // config writes
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [dofc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [dofc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    // Config registers.
    logic [dofc_pkg::RADIUS_BITS-1:0]   max_blur_radius_reg;
    logic [dofc_pkg::RADIUS_BITS-1:0]   near_dilation_reg;
    logic [dofc_pkg::STRENGTH_BITS-1:0] effect_strength_reg;
    logic [dofc_pkg::WEIGHT_BITS-1:0]   strength;

    // Global advance: every stage moves when the output register is free or drained.
    logic adv;

    logic                 front_valid;
    dofc_pkg::div_word_t  front_word;
    logic                 div_valid;
    dofc_pkg::div_word_t  div_word;
    logic                 sm_valid;
    dofc_pkg::pix_t       sm_pix;
    logic                 far_valid;
    logic [dofc_pkg::COLOR_BITS-1:0] far_c;
    dofc_pkg::pix_t       far_pix;
    logic                 near_valid;
    logic [dofc_pkg::COLOR_BITS-1:0] near_c;
    dofc_pkg::pix_t       near_pix;
    logic                 out_valid;
    logic [dofc_pkg::COLOR_BITS-1:0] out_c;
    dofc_pkg::pix_t       out_pix;

    assign cfg_ready = 1'b1;

    // Take config writes; mask data to each register's width, drop unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_blur_radius_reg <= dofc_pkg::RST_MAX_BLUR_RADIUS;
            near_dilation_reg   <= dofc_pkg::RST_NEAR_DILATION;
            effect_strength_reg <= dofc_pkg::RST_EFFECT_STRENGTH;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dofc_pkg::REG_MAX_BLUR_RADIUS: begin
                    max_blur_radius_reg <= cfg_data[dofc_pkg::RADIUS_BITS-1:0];
                end
                dofc_pkg::REG_NEAR_DILATION: begin
                    near_dilation_reg <= cfg_data[dofc_pkg::RADIUS_BITS-1:0];
                end
                dofc_pkg::REG_EFFECT_STRENGTH: begin
                    effect_strength_reg <= cfg_data[dofc_pkg::STRENGTH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Strength above one acts as one.
    assign strength = (effect_strength_reg > dofc_pkg::ONE_Q16) ? dofc_pkg::ONE_Q16
                                                                 : effect_strength_reg;

    // Hold the whole pipe only while a result word sits unclaimed.
    assign adv     = !out_valid || m_ready;
    assign s_ready = adv;

    dofc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (s_valid),
        .coc_size        (s_coc_size),
        .sharp_color     (s_sharp_color),
        .near_blur_color (s_near_blur_color),
        .far_blur_color  (s_far_blur_color),
        .max_blur_radius (max_blur_radius_reg),
        .near_dilation   (near_dilation_reg),
        .out_valid       (front_valid),
        .out_word        (front_word)
    );

    dofc_divider u_divider (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (front_valid),
        .in_word         (front_word),
        .max_blur_radius (max_blur_radius_reg),
        .out_valid       (div_valid),
        .out_word        (div_word)
    );

    dofc_smooth u_smooth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_word   (div_word),
        .out_valid (sm_valid),
        .out_pix   (sm_pix)
    );

    // Sharp toward far.
    dofc_blend u_blend_far (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sm_valid),
        .a         (sm_pix.sharp),
        .b         (sm_pix.far_color),
        .t         (sm_pix.wf),
        .in_pix    (sm_pix),
        .out_valid (far_valid),
        .out_color (far_c),
        .out_pix   (far_pix)
    );

    // Then toward near.
    dofc_blend u_blend_near (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (far_valid),
        .a         (far_c),
        .b         (far_pix.near_color),
        .t         (far_pix.wn),
        .in_pix    (far_pix),
        .out_valid (near_valid),
        .out_color (near_c),
        .out_pix   (near_pix)
    );

    // Scale the whole effect by strength; this register is the output register.
    dofc_blend u_blend_strength (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (near_valid),
        .a         (near_pix.sharp),
        .b         (near_c),
        .t         (strength),
        .in_pix    (near_pix),
        .out_valid (out_valid),
        .out_color (out_c),
        .out_pix   (out_pix)
    );

    assign m_valid        = out_valid;
    assign m_result_color = out_c;
    assign m_near_weight  = out_pix.wn;
    assign m_far_weight   = out_pix.wf;

`ifndef SYNTH
    // Only one side of focus can carry a weight.
    a_weights_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_near_weight == '0) || (m_far_weight == '0))
        else $error("near and far weights both nonzero");

    // Weights never exceed one.
    a_weights_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_near_weight <= dofc_pkg::ONE_Q16) && (m_far_weight <= dofc_pkg::ONE_Q16))
        else $error("weight above one");

    // Input back pressure comes only from a stalled result word.
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back pressure");

    // A word in the last-but-one stage reaches the output on the next advance.
    a_tail_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && near_valid |=> m_valid)
        else $error("word lost before output register");
`endif

endmodule

`default_nettype wire
